// ===== hdl/dls_pkg.sv =====
// shared types, constants and timer helpers for the door lock supervisor
package dls_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [CFG_W-1:0]      t_cfg_word;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    localparam t_cfg_idx CFG_REED_DEB    = 3'd0;
    localparam t_cfg_idx CFG_LATCH_DEB   = 3'd1;
    localparam t_cfg_idx CFG_BEAM_DEB    = 3'd2;
    localparam t_cfg_idx CFG_MORTISE_DEB = 3'd3;
    localparam t_cfg_idx CFG_PULSE       = 3'd4;
    localparam t_cfg_idx CFG_FLASH       = 3'd5;

    localparam t_cfg_word DEB_RST   = 16'd50;
    localparam t_cfg_word PULSE_RST = 16'd500;
    localparam t_cfg_word FLASH_RST = 16'd250;

    localparam logic BEAM_RST_LEVEL  = 1'b1;
    localparam logic OTHER_RST_LEVEL = 1'b0;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_UNLOCK = 2'd1,
        CMD_READY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_INIT     = 2'd0,
        MODE_SECURE   = 2'd1,
        MODE_UNLOCKED = 2'd2,
        MODE_ALARM    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        TRIG_NONE          = 3'd0,
        TRIG_SIGNED        = 3'd1,
        TRIG_ALARM_TIMEOUT = 3'd2,
        TRIG_DOOR_CLOSE    = 3'd3,
        TRIG_MORTISE       = 3'd4
    } t_trigger;

    typedef struct packed {
        t_cfg_word reed_deb;
        t_cfg_word latch_deb;
        t_cfg_word beam_deb;
        t_cfg_word mortise_deb;
        t_cfg_word pulse;
        t_cfg_word flash;
    } t_cfg;

    typedef struct packed {
        t_mode    mode;
        t_trigger trigger;
        logic     pulse_on;
        logic     led_lit;
    } t_lock_status;

    typedef struct packed {
        logic [1:0] lock_state;
        logic [2:0] last_trigger;
        logic       solenoid_on;
        logic       alarm_led;
        logic       door_shut;
        logic       latch_engaged;
        logic       beam_broken;
        logic       mortise_thrown;
        logic       door_secure;
    } t_rsp;

    function automatic t_timer timer_inc(input t_timer t);
        return (t == {TIMER_BITS{1'b1}}) ? t : t + t_timer'(1);
    endfunction

    function automatic logic timer_reached(input t_timer t, input t_cfg_word lim);
        return CMP_W'(t) >= CMP_W'(lim);
    endfunction

endpackage

// ===== hdl/dls_req_if.sv =====
// request channel: command and raw switch levels
interface dls_req_if;
    import dls_pkg::*;

    logic valid;
    logic ready;
    t_cmd cmd;
    logic reed_raw;
    logic latch_raw;
    logic beam_raw;
    logic mortise_raw;

    modport source (output valid, cmd, reed_raw, latch_raw, beam_raw, mortise_raw,
                    input ready);
    modport sink (input valid, cmd, reed_raw, latch_raw, beam_raw, mortise_raw,
                  output ready);
endinterface

// ===== hdl/dls_rsp_if.sv =====
// status channel: lock state, last trigger, solenoid and alarm outputs and debounced levels
interface dls_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] lock_state;
    logic [2:0] last_trigger;
    logic       solenoid_on;
    logic       alarm_led;
    logic       door_shut;
    logic       latch_engaged;
    logic       beam_broken;
    logic       mortise_thrown;
    logic       door_secure;

    modport source (output valid, lock_state, last_trigger, solenoid_on, alarm_led,
                    door_shut, latch_engaged, beam_broken, mortise_thrown, door_secure,
                    input ready);
    modport sink (input valid, lock_state, last_trigger, solenoid_on, alarm_led,
                  door_shut, latch_engaged, beam_broken, mortise_thrown, door_secure,
                  output ready);
endinterface

// ===== hdl/dls_cfg_regs.sv =====
// configuration register file for debounce, pulse and flash times
module dls_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  dls_pkg::t_cfg_idx  i_wr_idx,
    input  dls_pkg::t_cfg_word i_wr_data,
    output dls_pkg::t_cfg      o_cfg
);
    import dls_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_idx)
                CFG_REED_DEB:    n_cfg.reed_deb    = i_wr_data;
                CFG_LATCH_DEB:   n_cfg.latch_deb   = i_wr_data;
                CFG_BEAM_DEB:    n_cfg.beam_deb    = i_wr_data;
                CFG_MORTISE_DEB: n_cfg.mortise_deb = i_wr_data;
                CFG_PULSE:       n_cfg.pulse       = i_wr_data;
                CFG_FLASH:       n_cfg.flash       = i_wr_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reed_deb    <= DEB_RST;
            r_cfg.latch_deb   <= DEB_RST;
            r_cfg.beam_deb    <= DEB_RST;
            r_cfg.mortise_deb <= DEB_RST;
            r_cfg.pulse       <= PULSE_RST;
            r_cfg.flash       <= FLASH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hdl/dls_debounce.sv =====
// debounce qualifier for one switch
module dls_debounce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rst_level,
    input  logic              i_tick,
    input  logic              i_raw,
    input  dls_pkg::t_cfg_word i_limit,
    output logic              o_level_next
);
    import dls_pkg::*;

    logic   r_level;
    logic   r_running;
    t_timer r_elapsed;
    logic   n_level;
    logic   n_running;
    t_timer n_elapsed;
    t_timer inc;

    always_comb begin
        inc       = timer_inc(r_elapsed);
        n_level   = r_level;
        n_running = 1'b0;
        n_elapsed = '0;
        if (i_raw != r_level) begin
            if (!r_running) begin
                n_running = 1'b1;
            end else if (timer_reached(inc, i_limit)) begin
                n_level = i_raw;
            end else begin
                n_running = 1'b1;
                n_elapsed = inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= i_rst_level;
            r_running <= 1'b0;
            r_elapsed <= '0;
        end else if (i_tick) begin
            r_level   <= n_level;
            r_running <= n_running;
            r_elapsed <= n_elapsed;
        end
    end

    // level after this request, whether or not it is a tick
    assign o_level_next = i_tick ? n_level : r_level;
endmodule

// ===== hdl/dls_lock_fsm.sv =====
// lock state machine with solenoid pulse and alarm flash timers
module dls_lock_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  dls_pkg::t_cmd         i_cmd,
    input  logic                 i_reed,
    input  logic                 i_latch,
    input  logic                 i_mortise,
    input  dls_pkg::t_cfg_word    i_pulse_ms,
    input  dls_pkg::t_cfg_word    i_flash_ms,
    output dls_pkg::t_lock_status o_status
);
    import dls_pkg::*;

    t_mode    r_mode;
    t_trigger r_trigger;
    logic     r_pulse;
    t_timer   r_pulse_el;
    logic     r_led;
    t_timer   r_flash_el;

    t_mode    n_mode;
    t_trigger n_trigger;
    logic     n_pulse;
    t_timer   n_pulse_el;
    logic     n_led;
    t_timer   n_flash_el;

    t_timer   pulse_inc;
    t_timer   flash_inc;

    always_comb begin
        pulse_inc  = timer_inc(r_pulse_el);
        flash_inc  = timer_inc(r_flash_el);
        n_mode     = r_mode;
        n_trigger  = r_trigger;
        n_pulse    = r_pulse;
        n_pulse_el = r_pulse_el;
        n_led      = r_led;
        n_flash_el = r_flash_el;
        unique case (i_cmd)
            CMD_TICK: begin
                unique case (r_mode)
                    MODE_SECURE: begin
                        if (!(i_reed && i_latch)) begin
                            if (r_pulse || !i_latch) begin
                                n_mode    = MODE_UNLOCKED;
                                n_trigger = TRIG_SIGNED;
                            end else if (!i_reed) begin
                                n_mode    = MODE_ALARM;
                                n_trigger = TRIG_ALARM_TIMEOUT;
                            end
                        end
                    end
                    MODE_UNLOCKED: begin
                        if (i_latch) begin
                            n_mode    = MODE_SECURE;
                            n_trigger = TRIG_DOOR_CLOSE;
                        end else if (i_mortise) begin
                            n_mode    = MODE_ALARM;
                            n_trigger = TRIG_MORTISE;
                        end
                    end
                    MODE_ALARM: begin
                        if (!i_mortise && i_latch && i_reed) begin
                            n_mode    = MODE_SECURE;
                            n_trigger = TRIG_DOOR_CLOSE;
                        end
                    end
                    default: n_mode = r_mode;
                endcase
                if (r_pulse) begin
                    n_pulse_el = pulse_inc;
                    if (timer_reached(pulse_inc, i_pulse_ms)) begin
                        n_pulse = 1'b0;
                    end
                end
                n_flash_el = flash_inc;
                if (n_mode == MODE_ALARM && timer_reached(flash_inc, i_flash_ms)) begin
                    n_led      = !r_led;
                    n_flash_el = '0;
                end
            end
            CMD_UNLOCK: begin
                n_pulse    = 1'b1;
                n_pulse_el = '0;
                n_mode     = MODE_UNLOCKED;
                n_trigger  = TRIG_SIGNED;
            end
            CMD_READY: begin
                if (r_mode == MODE_INIT) begin
                    n_mode = MODE_SECURE;
                end
            end
            default: n_mode = r_mode;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_INIT;
            r_trigger  <= TRIG_NONE;
            r_pulse    <= 1'b0;
            r_pulse_el <= '0;
            r_led      <= 1'b0;
            r_flash_el <= '0;
        end else if (i_go) begin
            r_mode     <= n_mode;
            r_trigger  <= n_trigger;
            r_pulse    <= n_pulse;
            r_pulse_el <= n_pulse_el;
            r_led      <= n_led;
            r_flash_el <= n_flash_el;
        end
    end

    assign o_status.mode     = n_mode;
    assign o_status.trigger  = n_trigger;
    assign o_status.pulse_on = n_pulse;
    assign o_status.led_lit  = n_led;
endmodule

// ===== hdl/door_lock_supervisor_unit.sv =====
// door lock supervisor top level
//
//  channel   dir  handshake        payload
//  i_req     in   valid / ready    cmd, reed_raw, latch_raw, beam_raw, mortise_raw
//  o_rsp     out  valid / ready    lock_state, last_trigger, solenoid_on, alarm_led,
//                                  door_shut, latch_engaged, beam_broken,
//                                  mortise_thrown, door_secure
//  i_cfg_*   in   write enable     i_cfg_idx, i_cfg_data
//
// one request per cycle back to back while o_rsp is ready; an accepted request is held
// in the input register, then its status is loaded into the status register on o_rsp
// reset is synchronous and leaves every config register at its default
// a held status stops the input register; one more request can still enter it while
// it is empty, after that the input stalls until the status is taken
module door_lock_supervisor_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dls_req_if.sink            i_req,
    dls_rsp_if.source          o_rsp,
    input  logic               i_cfg_wr_en,
    input  dls_pkg::t_cfg_idx   i_cfg_idx,
    input  dls_pkg::t_cfg_word  i_cfg_data
);
    import dls_pkg::*;

    t_cfg         cfg;
    t_lock_status status;

    logic r_in_valid;
    t_cmd r_cmd;
    logic r_reed_raw;
    logic r_latch_raw;
    logic r_beam_raw;
    logic r_mortise_raw;

    logic r_out_valid;
    t_rsp r_out;
    t_rsp n_out;

    logic go;
    logic tick;
    logic accept;
    logic reed_lvl;
    logic latch_lvl;
    logic beam_lvl;
    logic mortise_lvl;

    assign go     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign tick   = go && (r_cmd == CMD_TICK);
    assign accept = i_req.valid && i_req.ready;

    assign i_req.ready = !r_in_valid || go;

    dls_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_wr_idx  (i_cfg_idx),
        .i_wr_data (i_cfg_data),
        .o_cfg     (cfg)
    );

    dls_debounce u_deb_reed (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rst_level  (OTHER_RST_LEVEL),
        .i_tick       (tick),
        .i_raw        (r_reed_raw),
        .i_limit      (cfg.reed_deb),
        .o_level_next (reed_lvl)
    );

    dls_debounce u_deb_latch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rst_level  (OTHER_RST_LEVEL),
        .i_tick       (tick),
        .i_raw        (r_latch_raw),
        .i_limit      (cfg.latch_deb),
        .o_level_next (latch_lvl)
    );

    dls_debounce u_deb_beam (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rst_level  (BEAM_RST_LEVEL),
        .i_tick       (tick),
        .i_raw        (r_beam_raw),
        .i_limit      (cfg.beam_deb),
        .o_level_next (beam_lvl)
    );

    dls_debounce u_deb_mortise (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rst_level  (OTHER_RST_LEVEL),
        .i_tick       (tick),
        .i_raw        (r_mortise_raw),
        .i_limit      (cfg.mortise_deb),
        .o_level_next (mortise_lvl)
    );

    dls_lock_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_cmd      (r_cmd),
        .i_reed     (reed_lvl),
        .i_latch    (latch_lvl),
        .i_mortise  (mortise_lvl),
        .i_pulse_ms (cfg.pulse),
        .i_flash_ms (cfg.flash),
        .o_status   (status)
    );

    always_comb begin
        n_out.lock_state     = status.mode;
        n_out.last_trigger   = status.trigger;
        n_out.solenoid_on    = status.pulse_on;
        n_out.alarm_led      = status.led_lit;
        n_out.door_shut      = reed_lvl;
        n_out.latch_engaged  = latch_lvl;
        n_out.beam_broken    = beam_lvl;
        n_out.mortise_thrown = mortise_lvl;
        n_out.door_secure    = reed_lvl && latch_lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd         <= i_req.cmd;
            r_reed_raw    <= i_req.reed_raw;
            r_latch_raw   <= i_req.latch_raw;
            r_beam_raw    <= i_req.beam_raw;
            r_mortise_raw <= i_req.mortise_raw;
        end
        if (go) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.lock_state     = r_out.lock_state;
    assign o_rsp.last_trigger   = r_out.last_trigger;
    assign o_rsp.solenoid_on    = r_out.solenoid_on;
    assign o_rsp.alarm_led      = r_out.alarm_led;
    assign o_rsp.door_shut      = r_out.door_shut;
    assign o_rsp.latch_engaged  = r_out.latch_engaged;
    assign o_rsp.beam_broken    = r_out.beam_broken;
    assign o_rsp.mortise_thrown = r_out.mortise_thrown;
    assign o_rsp.door_secure    = r_out.door_secure;
endmodule
